/* design/window_voltage_fault_detector_unit_defines.svh */
// assertion macros shared by the window voltage fault detector rtl
// expects clk and rst in the scope where a macro is used
`ifndef WINDOW_VOLTAGE_FAULT_DETECTOR_UNIT_DEFINES_SVH
`define WINDOW_VOLTAGE_FAULT_DETECTOR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define WVFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WVFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/wvfd_pkg.sv */
// shared types and constants for the window voltage fault detector
// no dependencies
package wvfd_pkg;

  localparam int WINDOW_SAMPLES = 10;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 15;
  localparam int CODE_W   = 3;
  localparam int OFF_W    = 4;
  localparam int NUM_THR  = 4;

  localparam int CNT_W  = $clog2(WINDOW_SAMPLES);
  localparam int SQ_W   = 2 * SAMPLE_W - 1;
  localparam int SUM_W  = SQ_W + $clog2(WINDOW_SAMPLES);

  // restoring square root, one result bit per step
  localparam int SQRT_STEPS = SAMPLE_W;
  localparam int STEP_W     = $clog2(SQRT_STEPS);
  localparam int RES_W      = 2 * SQRT_STEPS;
  localparam int BIT_W      = 2 * SQRT_STEPS - 1;
  localparam int PROD_W     = RES_W + $clog2(WINDOW_SAMPLES);
  localparam int TSQ_W      = 2 * THR_W;
  localparam int LIM_W      = TSQ_W + $clog2(WINDOW_SAMPLES);

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SWELL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OVER  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SAG   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNDER = CFG_IDX_W'(3);

  localparam logic [THR_W-1:0] SWELL_RESET = THR_W'(11000);
  localparam logic [THR_W-1:0] OVER_RESET  = THR_W'(10700);
  localparam logic [THR_W-1:0] SAG_RESET   = THR_W'(9000);
  localparam logic [THR_W-1:0] UNDER_RESET = THR_W'(9300);

  localparam logic [BIT_W-1:0] BIT_INIT  = BIT_W'(1) << (2 * (SQRT_STEPS - 1));
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SQRT_STEPS - 1);

  typedef enum logic [CODE_W-1:0] {
    FAULT_CLEAR = 3'd0,
    FAULT_SWELL = 3'd1,
    FAULT_OVER  = 3'd2,
    FAULT_SAG   = 3'd3,
    FAULT_UNDER = 3'd4
  } fault_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROOT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              sample_en;
    logic              calc_init;
    logic              calc_en;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic window_last;
  } stat_t;

endpackage

/* design/wvfd_ctrl.sv */
// controller fsm: sample acceptance, square root sequencing, result handoff
// depends on wvfd_pkg and window_voltage_fault_detector_unit_defines.svh
`include "window_voltage_fault_detector_unit_defines.svh"

module wvfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  wvfd_pkg::stat_t stat,
  output wvfd_pkg::cmd_t  cmd
);
  import wvfd_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_COLLECT: begin
        in_ready      = 1'b1;
        cmd.sample_en = in_valid;
        if (in_valid && stat.window_last) begin
          cmd.calc_init = 1'b1;
          step_next     = '0;
          state_next    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.calc_en = 1'b1;
        cmd.step    = step;
        if (step == STEP_LAST) begin
          state_next = ST_LOAD;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_LOAD: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  `WVFD_ASSERT_NEXT(a_close_starts_root, in_valid && in_ready && stat.window_last,
    state == ST_ROOT && step == '0, "closing sample did not start the root")
  `WVFD_ASSERT_NEXT(a_root_ends_in_load, state == ST_ROOT && step == STEP_LAST,
    state == ST_LOAD, "root sequence did not end in load")
  `WVFD_ASSERT_NEXT(a_load_waits, state == ST_LOAD && out_valid && !out_ready,
    state == ST_LOAD && out_valid, "pending result was overrun")

endmodule

/* design/wvfd_datapath.sv */
// datapath: window accumulators, threshold registers, square root and fault class
// depends on wvfd_pkg and window_voltage_fault_detector_unit_defines.svh
`include "window_voltage_fault_detector_unit_defines.svh"

module wvfd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wvfd_pkg::cmd_t                       cmd,
  output wvfd_pkg::stat_t                      stat,
  input  logic                                 cfg_write,
  input  logic [wvfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wvfd_pkg::THR_W-1:0]           cfg_data,
  input  logic signed [wvfd_pkg::SAMPLE_W-1:0] voltage_sample,
  input  logic [wvfd_pkg::TIME_W-1:0]          sample_time,
  output logic [wvfd_pkg::CODE_W-1:0]          fault_code,
  output logic [wvfd_pkg::SAMPLE_W-1:0]        rms_value,
  output logic [wvfd_pkg::SAMPLE_W-1:0]        peak_to_peak,
  output logic [wvfd_pkg::SAMPLE_W-1:0]        max_step,
  output logic [wvfd_pkg::OFF_W-1:0]           max_step_offset,
  output logic [wvfd_pkg::TIME_W-1:0]          max_step_time
);
  import wvfd_pkg::*;

  // configuration
  logic [THR_W-1:0] swell_thr, over_thr, sag_thr, under_thr;

  // window state
  logic [CNT_W-1:0]           count;
  logic [SUM_W-1:0]           square_sum, sum_next;
  logic signed [SAMPLE_W-1:0] window_max, window_min, previous_sample;
  logic [SAMPLE_W-1:0]        largest_step;
  logic [OFF_W-1:0]           step_offset;
  logic [TIME_W-1:0]          step_time;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [SQ_W-1:0]              sq;
  logic signed [SAMPLE_W:0]     diff;
  logic [SAMPLE_W-1:0]          diff_abs;

  // square root
  logic [SUM_W-1:0]  rem;
  logic [RES_W-1:0]  res, trial;
  logic [BIT_W-1:0]  root_bit;
  logic [PROD_W-1:0] prod;
  logic              take;

  // threshold compare pipeline
  logic [THR_W-1:0]     thr_pick;
  logic [CFG_IDX_W-1:0] thr_sel, tidx;
  logic [TSQ_W-1:0]     tsq;
  logic [LIM_W-1:0]     lim;
  logic                 tvalid;
  logic                 gt_swell, gt_over, lt_sag, lt_under;
  fault_t               code;

  assign stat.window_last = (count == CNT_W'(WINDOW_SAMPLES - 1));

  always_comb begin
    sq_full  = (2*SAMPLE_W)'(voltage_sample) * (2*SAMPLE_W)'(voltage_sample);
    sq       = sq_full[SQ_W-1:0];
    diff     = {voltage_sample[SAMPLE_W-1], voltage_sample}
             - {previous_sample[SAMPLE_W-1], previous_sample};
    diff_abs = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    sum_next = (count == '0) ? SUM_W'(sq) : square_sum + SUM_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swell_thr <= SWELL_RESET;
      over_thr  <= OVER_RESET;
      sag_thr   <= SAG_RESET;
      under_thr <= UNDER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SWELL: swell_thr <= cfg_data;
        REG_OVER:  over_thr  <= cfg_data;
        REG_SAG:   sag_thr   <= cfg_data;
        REG_UNDER: under_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.sample_en) begin
      count <= stat.window_last ? '0 : count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_en) begin
      square_sum      <= sum_next;
      previous_sample <= voltage_sample;
      if (count == '0) begin
        window_max   <= voltage_sample;
        window_min   <= voltage_sample;
        largest_step <= '0;
        step_offset  <= '0;
        step_time    <= sample_time;
      end else begin
        if (voltage_sample > window_max) window_max <= voltage_sample;
        if (voltage_sample < window_min) window_min <= voltage_sample;
        // strictly larger only, so the first maximum stays
        if (diff_abs > largest_step) begin
          largest_step <= diff_abs;
          step_offset  <= OFF_W'(count);
          step_time    <= sample_time;
        end
      end
    end
  end

  // floor(sqrt(S/N)) found directly on S by scaling each trial by N
  always_comb begin
    trial = res + RES_W'(root_bit);
    prod  = PROD_W'(trial) * PROD_W'(WINDOW_SAMPLES);
    take  = PROD_W'(rem) >= prod;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_init) begin
      rem      <= sum_next;
      res      <= '0;
      root_bit <= BIT_INIT;
    end else if (cmd.calc_en) begin
      if (take) begin
        rem <= rem - SUM_W'(prod);
        res <= (res >> 1) + RES_W'(root_bit);
      end else begin
        res <= res >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  // thresholds squared on steps 0..3, compared against N*T^2 in the following cycle
  always_comb begin
    thr_sel = CFG_IDX_W'(cmd.step);
    case (thr_sel)
      REG_SWELL: thr_pick = swell_thr;
      REG_OVER:  thr_pick = over_thr;
      REG_SAG:   thr_pick = sag_thr;
      REG_UNDER: thr_pick = under_thr;
      default:   thr_pick = '0;
    endcase
    lim = LIM_W'(tsq) * LIM_W'(WINDOW_SAMPLES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else begin
      tvalid <= cmd.calc_en && (cmd.step < STEP_W'(NUM_THR));
    end
  end

  always_ff @(posedge clk) begin
    tsq  <= TSQ_W'(thr_pick) * TSQ_W'(thr_pick);
    tidx <= thr_sel;
    if (cmd.calc_init) begin
      gt_swell <= 1'b0;
      gt_over  <= 1'b0;
      lt_sag   <= 1'b0;
      lt_under <= 1'b0;
    end else if (tvalid) begin
      case (tidx)
        REG_SWELL: gt_swell <= square_sum > SUM_W'(lim);
        REG_OVER:  gt_over  <= square_sum > SUM_W'(lim);
        REG_SAG:   lt_sag   <= square_sum < SUM_W'(lim);
        REG_UNDER: lt_under <= square_sum < SUM_W'(lim);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gt_swell)      code = FAULT_SWELL;
    else if (gt_over)  code = FAULT_OVER;
    else if (lt_sag)   code = FAULT_SAG;
    else if (lt_under) code = FAULT_UNDER;
    else               code = FAULT_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      fault_code      <= code;
      rms_value       <= res[SAMPLE_W-1:0];
      peak_to_peak    <= window_max - window_min;
      max_step        <= largest_step;
      max_step_offset <= step_offset;
      max_step_time   <= step_time;
    end
  end

  `WVFD_ASSERT_NEXT(a_root_init, cmd.calc_init,
    res == '0 && root_bit == BIT_INIT, "root unit not initialized")
  `WVFD_ASSERT_NEXT(a_window_wraps, cmd.sample_en && stat.window_last,
    count == '0, "sample count did not wrap at window end")
  `WVFD_ASSERT_NOW(a_init_on_close, cmd.calc_init,
    cmd.sample_en && stat.window_last, "root started without closing sample")

endmodule

/* design/window_voltage_fault_detector_unit.sv */
// Windowed RMS voltage fault detector, top level.
// Input channel (in_valid/in_ready) carries voltage_sample and sample_time; each
// accepted transaction adds one sample to the current window of WINDOW_SAMPLES.
// Samples that do not close a window are taken one per cycle and give no result.
// The sample that closes a window starts a square root of 16 steps (one result
// bit per cycle on a shared compare/subtract unit, scaled by N so no divide is
// needed); the four threshold tests run alongside it. in_ready stays low from
// that transaction through the root steps and the load step, and out_valid
// rises once the load step has stored the result.
// The result sits in an output register until out_ready takes it; the next
// window can be collected meanwhile, and a window that closes while the old
// result is still pending waits in its load step until the register frees.
// The cfg_write port sets thresholds immediately, in sample units.
// Synchronous reset restores the default thresholds, empties the window and
// drops any pending result.
// Depends on wvfd_pkg, wvfd_ctrl and wvfd_datapath.
module window_voltage_fault_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wvfd_pkg::SAMPLE_W-1:0] voltage_sample,
  input  logic [wvfd_pkg::TIME_W-1:0]          sample_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wvfd_pkg::CODE_W-1:0]          fault_code,
  output logic [wvfd_pkg::SAMPLE_W-1:0]        rms_value,
  output logic [wvfd_pkg::SAMPLE_W-1:0]        peak_to_peak,
  output logic [wvfd_pkg::SAMPLE_W-1:0]        max_step,
  output logic [wvfd_pkg::OFF_W-1:0]           max_step_offset,
  output logic [wvfd_pkg::TIME_W-1:0]          max_step_time,
  input  logic                                 cfg_write,
  input  logic [wvfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wvfd_pkg::THR_W-1:0]           cfg_data
);
  import wvfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wvfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wvfd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .voltage_sample  (voltage_sample),
    .sample_time     (sample_time),
    .fault_code      (fault_code),
    .rms_value       (rms_value),
    .peak_to_peak    (peak_to_peak),
    .max_step        (max_step),
    .max_step_offset (max_step_offset),
    .max_step_time   (max_step_time)
  );

endmodule

/* tb/testbench.sv */
// self-checking testbench for window_voltage_fault_detector_unit
// predicts each window summary in a scoreboard class and checks the output channel against it
// depends on wvfd_pkg and the detector rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wvfd_pkg::*;

  typedef struct packed {
    fault_t                code;
    logic [SAMPLE_W-1:0]   rms;
    logic [SAMPLE_W-1:0]   p2p;
    logic [SAMPLE_W-1:0]   step;
    logic [OFF_W-1:0]      off;
    logic [TIME_W-1:0]     stamp;
  } window_summary_t;

  class window_scoreboard;
    logic [THR_W-1:0]  limits[NUM_THR];
    int                fill;
    longint unsigned   energy;
    int                peak_hi;
    int                peak_lo;
    int                last_sample;
    int                steepest;
    int                steep_pos;
    logic [TIME_W-1:0] steep_stamp;
    window_summary_t   expected[$];
    int                mismatches;

    function new();
      limits[REG_SWELL] = SWELL_RESET;
      limits[REG_OVER]  = OVER_RESET;
      limits[REG_SAG]   = SAG_RESET;
      limits[REG_UNDER] = UNDER_RESET;
      fill = 0;
      energy = 0;
      peak_hi = 0;
      peak_lo = 0;
      last_sample = 0;
      steepest = 0;
      steep_pos = 0;
      steep_stamp = '0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
      // indexes past the threshold bank are dropped by the block
      if (idx < NUM_THR) limits[idx] = data;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return r;
    endfunction

    // window energy at which the mean square equals the threshold squared
    function longint unsigned window_bound(logic [THR_W-1:0] t);
      longint unsigned tt;
      tt = t;
      return longint'(WINDOW_SAMPLES) * tt * tt;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] v, logic [TIME_W-1:0] ts);
      int              s;
      int              d;
      window_summary_t r;
      s = v;
      if (fill == 0) begin
        peak_hi = s;
        peak_lo = s;
        energy = longint'(s * s);
        steepest = 0;
        steep_pos = 0;
        steep_stamp = ts;
      end else begin
        d = s - last_sample;
        if (d < 0) d = -d;
        energy += longint'(s * s);
        if (s > peak_hi) peak_hi = s;
        if (s < peak_lo) peak_lo = s;
        // only a strictly larger step moves the marker
        if (d > steepest) begin
          steepest = d;
          steep_pos = fill;
          steep_stamp = ts;
        end
      end
      last_sample = s;
      fill++;
      if (fill == WINDOW_SAMPLES) begin
        fill = 0;
        if (energy > window_bound(limits[REG_SWELL]))
          r.code = FAULT_SWELL;
        else if (energy > window_bound(limits[REG_OVER]))
          r.code = FAULT_OVER;
        else if (energy < window_bound(limits[REG_SAG]))
          r.code = FAULT_SAG;
        else if (energy < window_bound(limits[REG_UNDER]))
          r.code = FAULT_UNDER;
        else
          r.code = FAULT_CLEAR;
        r.rms = SAMPLE_W'(floor_root(energy / WINDOW_SAMPLES));
        r.p2p = SAMPLE_W'(peak_hi - peak_lo);
        r.step = SAMPLE_W'(steepest);
        r.off = OFF_W'(steep_pos);
        r.stamp = steep_stamp;
        expected.push_back(r);
      end
    endfunction

    function void check_result(window_summary_t got);
      window_summary_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: summary with no closed window, code %0d rms %0d p2p %0d",
                   got.code, got.rms, got.p2p);
        return;
      end
      want = expected.pop_front();
      if (got.code !== want.code || got.rms !== want.rms || got.p2p !== want.p2p ||
          got.step !== want.step || got.off !== want.off || got.stamp !== want.stamp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp code %0d rms %0d p2p %0d step %0d off %0d time %h",
                   want.code, want.rms, want.p2p, want.step, want.off, want.stamp);
          $display("          got code %0d rms %0d p2p %0d step %0d off %0d time %h",
                   got.code, got.rms, got.p2p, got.step, got.off, got.stamp);
        end
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  localparam logic [CFG_IDX_W-1:0] REG_BEYOND = CFG_IDX_W'(NUM_THR);
  localparam int NUM_PHASES = 8;
  localparam int WINDOWS_PER_PHASE = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 25;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] voltage_sample;
  logic [TIME_W-1:0]          sample_time;
  logic                       out_valid;
  logic                       out_ready;
  logic [CODE_W-1:0]          fault_code;
  logic [SAMPLE_W-1:0]        rms_value;
  logic [SAMPLE_W-1:0]        peak_to_peak;
  logic [SAMPLE_W-1:0]        max_step;
  logic [OFF_W-1:0]           max_step_offset;
  logic [TIME_W-1:0]          max_step_time;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [THR_W-1:0]           cfg_data;

  window_scoreboard sb;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  window_voltage_fault_detector_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .voltage_sample(voltage_sample),
    .sample_time(sample_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fault_code(fault_code),
    .rms_value(rms_value),
    .peak_to_peak(peak_to_peak),
    .max_step(max_step),
    .max_step_offset(max_step_offset),
    .max_step_time(max_step_time),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] saturate_sample(int x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return SAMPLE_W'(x);
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v, input logic [TIME_W-1:0] ts);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    voltage_sample <= v;
    sample_time <= ts;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(v, ts);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_threshold(idx, data);
  endtask

  // drop valid, let every closed window drain, then give the root a margin
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // output side: random back-pressure plus one long hold-off on request
  initial begin : drain
    int span;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 8);
        repeat (span - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        if (idle_on) begin
          span = $urandom_range(1, 16);
          repeat (span - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    window_summary_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.code = fault_t'(fault_code);
      seen.rms = rms_value;
      seen.p2p = peak_to_peak;
      seen.step = max_step;
      seen.off = max_step_offset;
      seen.stamp = max_step_time;
      sb.check_result(seen);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [THR_W-1:0]           setting[NUM_THR];
    logic [TIME_W-1:0]          ts;
    logic signed [SAMPLE_W-1:0] s;
    int                         mode;
    int                         level;
    int                         lvl_a;
    int                         lvl_b;
    bit                         free_time;

    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    voltage_sample = '0;
    sample_time = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // full-scale alternation: every step ties at 65535, first one must win
    for (int k = 0; k < WINDOW_SAMPLES; k++)
      offer_sample((k % 2 == 0) ? 16'sh7fff : 16'sh8000, (k == 1) ? 32'hffff_ffff : TIME_W'(k));
    // flat negative full scale: largest rms, no step so offset 0 and first timestamp
    for (int k = 0; k < WINDOW_SAMPLES; k++)
      offer_sample(16'sh8000, TIME_W'(1000 + k));
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: setting = '{15'h7fff, 15'h7fff, 15'h0000, 15'h0000};
          2: setting = '{15'h0000, 15'h0000, 15'h0000, 15'h0000};
          4: setting = '{THR_W'($urandom_range(10500, 11500)), THR_W'($urandom_range(10000, 10600)),
                         THR_W'($urandom_range(8500, 9200)), THR_W'($urandom_range(9200, 9800))};
          6: setting = '{15'h0000, 15'h7fff, 15'h7fff, 15'h0000};
          7: setting = '{SWELL_RESET, OVER_RESET, SAG_RESET, UNDER_RESET};
          default: begin
            foreach (setting[i]) setting[i] = THR_W'($urandom_range(0, 32767));
          end
        endcase
        write_threshold(REG_SWELL, setting[0]);
        write_threshold(REG_OVER, setting[1]);
        write_threshold(REG_SAG, setting[2]);
        write_threshold(REG_UNDER, setting[3]);
        if (p == 3) write_threshold(REG_BEYOND, THR_W'($urandom_range(0, 32767)));
        @(negedge clk);
        cfg_write <= 1'b0;
      end
      if (p == 1) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) idle_on = 1'b0;

      for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
        mode = $urandom_range(0, 9);
        ts = $urandom;
        free_time = ($urandom_range(0, 3) == 0);
        level = sb.limits[$urandom_range(0, NUM_THR - 1)];
        if (mode >= 2 && mode <= 4) level = level + $urandom_range(0, 40) - 20;
        if (mode == 6 || mode == 7) level = 10000 + $urandom_range(0, 1200) - 600;
        if (mode == 9) level = ($urandom_range(0, 1) == 0) ? 0 : int'($signed(16'($urandom)));
        lvl_a = $urandom_range(0, 20000);
        lvl_b = $urandom_range(0, 20000);
        for (int k = 0; k < WINDOW_SAMPLES; k++) begin
          case (mode)
            0, 1: s = SAMPLE_W'($urandom);
            2, 3, 4: begin
              s = saturate_sample(level + $urandom_range(0, 30) - 15);
              if ($urandom_range(0, 7) == 0) s = saturate_sample(-int'(s));
            end
            // sits exactly on a threshold, sign flips leave the energy unchanged
            5: s = ($urandom_range(0, 3) == 0) ? saturate_sample(-level) : saturate_sample(level);
            6, 7: s = saturate_sample(level + $urandom_range(0, 400) - 200);
            // two levels only, so equal steps recur
            8: s = ($urandom_range(0, 1) == 0) ? saturate_sample(lvl_a) : saturate_sample(lvl_b);
            default: s = saturate_sample(level);
          endcase
          offer_sample(s, free_time ? TIME_W'($urandom) : ts + TIME_W'(k));
        end
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/wvfd_pkg.sv
design/wvfd_ctrl.sv
design/wvfd_datapath.sv
design/window_voltage_fault_detector_unit.sv
tb/testbench.sv
